[hw/rtl/dmm_pkg.sv]
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants for the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // Default for the largest matrix dimension the store is built for
  localparam int unsigned MaxSizeDef = 16;
  // Row and column fields are 4 bits wide, so no more than 16 are addressable
  localparam int unsigned FieldLimit = 16;

  localparam int unsigned SizeW   = 5;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned AccW    = 36;

  localparam logic [SizeW-1:0] SizeRst = 5'd16;

  typedef enum logic {
    MODE_STORE = 1'b0,
    MODE_LEFT  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                    mode;
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic signed [ElemW-1:0]  elem_value;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0]          out_row;
    logic [IdxW-1:0]          out_col;
    logic signed [AccW-1:0]   result_value;
    logic                     last;
  } out_res_t;

endpackage

[hw/rtl/dmm_ram.sv]
// ----------------------------------------------------------------------------
// dmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dense_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// Streaming R = P x Q: right matrix into a store, left matrix streamed by row.
// ----------------------------------------------------------------------------
// Right-matrix (store) request: accepted one per cycle when idle.
// Left-matrix request: the input stalls until its pass over n stored
//   entries (n = active size) ends; one MAC per cycle unless a result stalls.
// Final left request of a row: results pass s0, s1, s2, then the out register.
// Reset: async, active low; clears control, accumulator valid bits, size=16.
// ----------------------------------------------------------------------------
module dense_matrix_multiply #(
  parameter int unsigned MAX_SIZE = dmm_pkg::MaxSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: active matrix size
  input  logic                          cfg_we_i,
  input  logic [dmm_pkg::SizeW-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dmm_pkg::in_req_t              in_req_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dmm_pkg::out_res_t             out_res_o
);

  // Largest usable size: bounded by the store and by the 4-bit index fields
  localparam int unsigned ActMax  = (MAX_SIZE < dmm_pkg::FieldLimit) ?
                                    MAX_SIZE : dmm_pkg::FieldLimit;
  localparam int unsigned AccAw   = (ActMax > 1) ? $clog2(ActMax) : 1;
  localparam int unsigned StDepth = MAX_SIZE * MAX_SIZE;
  localparam int unsigned StAw    = (StDepth > 1) ? $clog2(StDepth) : 1;

  localparam int unsigned IdxW  = dmm_pkg::IdxW;
  localparam int unsigned SizeW = dmm_pkg::SizeW;
  localparam int unsigned ElemW = dmm_pkg::ElemW;
  localparam int unsigned ProdW = dmm_pkg::ProdW;
  localparam int unsigned AccW  = dmm_pkg::AccW;

  // --------------------------------------------------------------------------
  // Configuration and active size
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] n_act;
  logic [IdxW-1:0]  nm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= dmm_pkg::SizeRst;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // zero acts as one; anything above the usable maximum is clamped
  always_comb begin
    if (size_q == '0) begin
      n_act = SizeW'(1);
    end else if (32'(size_q) > ActMax) begin
      n_act = SizeW'(ActMax);
    end else begin
      n_act = size_q;
    end
  end

  assign nm1 = IdxW'(n_act - SizeW'(1));

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic in_acc;
  logic busy;
  logic st_wr_ok;
  logic elem_ok;
  logic start;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // store writes ignore the active size, only the store bounds matter
  assign st_wr_ok = (in_req_i.mode == dmm_pkg::MODE_STORE) &&
                    (32'(in_req_i.row) < MAX_SIZE) &&
                    (32'(in_req_i.col) < MAX_SIZE);

  // left elements outside the active size are dropped silently
  assign elem_ok  = (in_req_i.mode == dmm_pkg::MODE_LEFT) &&
                    ({1'b0, in_req_i.row} < n_act) &&
                    ({1'b0, in_req_i.col} < n_act);

  assign start = in_acc && elem_ok;

  // --------------------------------------------------------------------------
  // Pipeline
  //   s0: issue read of Q[col][j] and accumulator j
  //   s1: RAM data back, multiply
  //   s2: add, write accumulator back, present result on the last column
  // All stages freeze together when a result in s2 cannot leave.
  // --------------------------------------------------------------------------
  logic                     adv;

  // s0 / per-element context
  logic                     iss_q;
  logic [IdxW-1:0]          j_q;
  logic [IdxW-1:0]          nm1_q;
  logic signed [ElemW-1:0]  p_q;
  logic [IdxW-1:0]          row_q;
  logic [IdxW-1:0]          col_q;
  logic                     emit_q;

  // s1
  logic                     s1_vld_q;
  logic [IdxW-1:0]          s1_j_q;
  logic                     s1_last_q;
  logic                     s1_avld_q;

  // s2
  logic                     s2_vld_q;
  logic [IdxW-1:0]          s2_j_q;
  logic                     s2_last_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [AccW-1:0]          accb_q;

  // accumulator valid bits: an entry not valid reads as zero
  logic [ActMax-1:0]        acc_vld_q;

  // output register
  logic                     out_valid_q;
  dmm_pkg::out_res_t        out_q;

  // RAM hookup
  logic                     st_we;
  logic [StAw-1:0]          st_waddr;
  logic [StAw-1:0]          st_raddr;
  logic [ElemW-1:0]         st_rdata;
  logic                     rd_en;
  logic                     acc_we;
  logic [AccW-1:0]          acc_wdata;
  logic [AccW-1:0]          acc_rdata;

  assign busy = iss_q || s1_vld_q || s2_vld_q;
  assign adv  = !(s2_vld_q && emit_q && out_valid_q && out_stall_i);

  assign st_we    = in_acc && st_wr_ok;
  assign st_waddr = StAw'(32'(in_req_i.row) * MAX_SIZE + 32'(in_req_i.col));
  assign st_raddr = StAw'(32'(col_q) * MAX_SIZE + 32'(j_q));
  assign rd_en    = iss_q && adv;

  // Q36.0 signed integer sum wraps at 36 bits; product is sign extended
  assign acc_we    = s2_vld_q && adv;
  assign acc_wdata = accb_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= 1'b0;
      j_q         <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        iss_q <= 1'b1;
        j_q   <= '0;
      end else if (rd_en) begin
        j_q <= j_q + IdxW'(1);
        if (j_q == nm1_q) begin
          iss_q <= 1'b0;
        end
      end

      if (adv) begin
        s1_vld_q <= iss_q;
        s2_vld_q <= s1_vld_q;
      end

      // column zero starts a fresh row
      if (start && (in_req_i.col == '0)) begin
        acc_vld_q <= '0;
      end else if (acc_we) begin
        acc_vld_q[AccAw'(s2_j_q)] <= 1'b1;
      end

      if (acc_we && emit_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      nm1_q  <= nm1;
      p_q    <= in_req_i.elem_value;
      row_q  <= in_req_i.row;
      col_q  <= in_req_i.col;
      emit_q <= (in_req_i.col == nm1);
    end
    if (adv) begin
      s1_j_q    <= j_q;
      s1_last_q <= (j_q == nm1_q);
      s1_avld_q <= acc_vld_q[AccAw'(j_q)];
      s2_j_q    <= s1_j_q;
      s2_last_q <= s1_last_q;
      prod_q    <= ProdW'(p_q) * ProdW'($signed(st_rdata));
      accb_q    <= s1_avld_q ? acc_rdata : '0;
    end
    if (acc_we && emit_q) begin
      out_q.out_row      <= row_q;
      out_q.out_col      <= s2_j_q;
      out_q.result_value <= $signed(acc_wdata);
      out_q.last         <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  dmm_ram #(
    .WIDTH (ElemW),
    .DEPTH (StDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (in_req_i.elem_value),
    .re_i    (rd_en),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  dmm_ram #(
    .WIDTH (AccW),
    .DEPTH (ActMax)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (AccAw'(s2_j_q)),
    .wdata_i (acc_wdata),
    .re_i    (rd_en),
    .raddr_i (AccAw'(j_q)),
    .rdata_o (acc_rdata)
  );

endmodule

[hw/rtl/dmm_checker.sv]
// ----------------------------------------------------------------------------
// dmm_checker
// Port-level checks for dense_matrix_multiply, bound to the top level.
// ----------------------------------------------------------------------------
module dmm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input dmm_pkg::in_req_t          in_req_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input dmm_pkg::out_res_t         out_res_o
);

  logic out_acc;
  logic in_acc;

  assign out_acc = out_valid_o && !out_stall_i;
  assign in_acc  = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // a row's results come back to back, columns ascending, same row
  a_row_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_res_o.last |=> out_valid_o &&
      (out_res_o.out_col == 4'($past(out_res_o.out_col) + 4'd1)) &&
      (out_res_o.out_row == $past(out_res_o.out_row)))
    else $error("broken result row");

  // no new request while a row is still being delivered
  a_row_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.last |-> in_stall_o)
    else $error("request taken mid-row");

  // a store write never produces a result
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.mode == dmm_pkg::MODE_STORE) && !out_valid_o
      |=> !out_valid_o)
    else $error("result after store write");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dense_matrix_multiply. Requests (right-matrix store
// writes and left-matrix elements) are queued per phase, sent by a clocked
// driver under random idling, and every result is checked field by field
// against a cycle-free model of the multiply kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxDim      = dmm_pkg::MaxSizeDef;
  // active size can never exceed what the 4-bit index fields address
  localparam int unsigned DimLimit    = (MaxDim < dmm_pkg::FieldLimit) ?
                                        MaxDim : dmm_pkg::FieldLimit;
  localparam int unsigned SizeW       = dmm_pkg::SizeW;
  localparam int unsigned IdxW        = dmm_pkg::IdxW;
  localparam int unsigned ElemW       = dmm_pkg::ElemW;
  localparam int unsigned ProdW       = dmm_pkg::ProdW;
  localparam int unsigned AccW        = dmm_pkg::AccW;
  // extra settling wait after the bench has drained, with margin
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned HoldCycles  = 400;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SizeW-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  dmm_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  dmm_pkg::out_res_t out_res_o;

  dense_matrix_multiply #(
    .MAX_SIZE(MaxDim)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  dmm_pkg::in_req_t  pending_requests[$];   // queued by the sequencer, popped by driver
  dmm_pkg::out_res_t expected_products[$];  // predicted results, oldest first

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_kicks     = 0; // bumped by the sequencer
  int unsigned hold_taken     = 0; // owned by the receiver process
  int unsigned hold_left      = 0;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned results_checked = 0;
  int unsigned rows_completed = 0;
  int unsigned mismatch_count = 0;

  // model of the block: store, accumulators, size register
  logic signed [ElemW-1:0] right_store [MaxDim][MaxDim];
  logic        [AccW-1:0]  row_acc     [MaxDim];
  logic        [SizeW-1:0] size_reg;

  // generator-side view: which store entries have been written so far
  bit          store_written [MaxDim][MaxDim];
  int unsigned gen_size;

  function automatic int unsigned active_dim(logic [SizeW-1:0] s);
    if (s == '0) return 1;
    if (s > DimLimit) return DimLimit;
    return 32'(s);
  endfunction

  // Apply one accepted request to the model, queue any results it completes.
  task automatic multiply_accumulate(dmm_pkg::in_req_t r);
    int unsigned n;
    int unsigned c;
    logic signed [ProdW-1:0] prod;
    dmm_pkg::out_res_t res;
    n = active_dim(size_reg);
    c = 32'(r.col);
    if (r.mode == dmm_pkg::MODE_STORE) begin
      right_store[r.row][r.col] = r.elem_value;
      return;
    end
    // out-of-range left elements are dropped silently
    if (r.row >= n || c >= n) return;
    if (c == 0) begin
      for (int j = 0; j < MaxDim; j++) row_acc[j] = '0;
    end
    for (int j = 0; j < n; j++) begin
      prod = ProdW'(r.elem_value) * ProdW'(right_store[c][j]);
      row_acc[j] = row_acc[j] + {{(AccW-ProdW){prod[ProdW-1]}}, prod};
    end
    if (c != n - 1) return;
    for (int j = 0; j < n; j++) begin
      res.out_row      = r.row;
      res.out_col      = IdxW'(j);
      res.result_value = row_acc[j];
      res.last         = (j == n - 1);
      expected_products.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, predicts on every accept
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        multiply_accumulate(in_req_i);
        accepted_count++;
      end
      // a held request stays put until taken
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req_i   <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall plus counted hold-off, checks each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dmm_pkg::out_res_t exp_res;
    if (hold_kicks != hold_taken) begin
      hold_taken = hold_kicks;
      hold_left  = HoldCycles;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_products.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %0d", out_res_o.out_row,
               out_res_o.out_col, out_res_o.result_value);
        mismatch_count++;
      end else begin
        exp_res = expected_products.pop_front();
        results_checked++;
        if (out_res_o.last) rows_completed++;
        if (out_res_o.out_row !== exp_res.out_row) begin
          $error("out_row mismatch: expected %0d, got %0d", exp_res.out_row,
                 out_res_o.out_row);
          mismatch_count++;
        end
        if (out_res_o.out_col !== exp_res.out_col) begin
          $error("out_col mismatch: expected %0d, got %0d", exp_res.out_col,
                 out_res_o.out_col);
          mismatch_count++;
        end
        if (out_res_o.result_value !== exp_res.result_value) begin
          $error("result_value mismatch: expected %0d, got %0d", exp_res.result_value,
                 out_res_o.result_value);
          mismatch_count++;
        end
        if (out_res_o.last !== exp_res.last) begin
          $error("last mismatch: expected %0d, got %0d", exp_res.last, out_res_o.last);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [ElemW-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return ElemW'($urandom);
    endcase
  endfunction

  task automatic queue_store(int unsigned r, int unsigned c, logic signed [ElemW-1:0] v);
    dmm_pkg::in_req_t q;
    q.mode       = dmm_pkg::MODE_STORE;
    q.row        = IdxW'(r);
    q.col        = IdxW'(c);
    q.elem_value = v;
    pending_requests.push_back(q);
    store_written[r][c] = 1'b1;
    queued_count++;
  endtask

  // Left element; first fills any store entry it would read that is still blank.
  task automatic queue_left(int unsigned r, int unsigned c, logic signed [ElemW-1:0] v);
    dmm_pkg::in_req_t q;
    if (r < gen_size && c < gen_size) begin
      for (int j = 0; j < gen_size; j++) begin
        if (!store_written[c][j]) queue_store(c, j, pick_elem());
      end
    end
    q.mode       = dmm_pkg::MODE_LEFT;
    q.row        = IdxW'(r);
    q.col        = IdxW'(c);
    q.elem_value = v;
    pending_requests.push_back(q);
    queued_count++;
  endtask

  // mangle: 0 = clean row, 1 = one column dropped, 2 = one column sent twice
  task automatic queue_row(int unsigned r, int unsigned mangle);
    int unsigned target;
    target = $urandom_range(0, gen_size - 1);
    for (int k = 0; k < gen_size; k++) begin
      if (!(mangle == 1 && k == target)) queue_left(r, k, pick_elem());
      if (mangle == 2 && k == target) queue_left(r, k, pick_elem());
    end
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 1) == 0) begin
      queue_store($urandom_range(0, 15), $urandom_range(0, 15), ElemW'($urandom));
    end else begin
      queue_left($urandom_range(0, 15), $urandom_range(0, 15), pick_elem());
    end
  endtask

  // Sender pause: nothing in flight, nothing expected, block given time to settle.
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_products.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_size(logic [SizeW-1:0] s);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    size_reg     = s;
    gen_size     = active_dim(s);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed rows with random content, some broken rows and noise.
  task automatic run_segment(int unsigned budget);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_row($urandom_range(0, gen_size - 1), 0);
        done += gen_size;
      end else if (pick < 8) begin
        queue_row($urandom_range(0, gen_size - 1), $urandom_range(1, 2));
        done += gen_size;
      end else begin
        queue_noise();
        done++;
      end
    end
    wait_drained();
  endtask

  task automatic run_phase(logic [SizeW-1:0] s, int unsigned budget);
    apply_size(s);
    run_segment(budget / 2 + 1);
    run_segment(budget / 2);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MaxDim; i++) begin
      row_acc[i] = '0;
      for (int j = 0; j < MaxDim; j++) begin
        right_store[i][j]   = '0;
        store_written[i][j] = 1'b0;
      end
    end
    size_reg = dmm_pkg::SizeRst;
    gen_size = active_dim(dmm_pkg::SizeRst);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed: 2x2 with extreme values and the odd cases ----
    send_idle_pct  = 36;
    recv_stall_pct = 48;
    apply_size(5'd2);
    queue_store(0, 0, 16'sh8000);
    queue_store(0, 1, 16'sh7fff);
    queue_store(1, 0, 16'sh8000);
    queue_store(1, 1, '0);
    queue_left(0, 1, 16'sh8000);     // row with no column 0, straight after reset
    queue_left(1, 0, 16'sh8000);     // clean row, largest product
    queue_left(1, 1, 16'sh7fff);
    queue_left(1, 0, 16'sh7fff);     // column 0 twice
    queue_left(1, 0, 16'sh8000);
    queue_left(1, 1, 16'sh8000);
    queue_left(0, 1, 16'sh7fff);     // keeps adding to the old sums
    queue_left(2, 0, 16'sh7fff);     // row beyond size: dropped
    queue_left(0, 3, 16'sh7fff);     // column beyond size: dropped
    queue_left(15, 15, 16'sh8000);   // both beyond size: dropped
    queue_store(15, 15, 16'sh7fff);  // top corner of the store
    queue_store(8, 7, 16'sh8000);
    queue_left(0, 0, '0);            // all-zero row
    queue_left(0, 1, '0);
    queue_left(1, 0, 16'sh0001);
    queue_left(1, 1, 16'shffff);
    // 33 adds of the largest product wrap the 36-bit sums
    queue_store(1, 0, 16'sh8000);
    queue_store(1, 1, 16'sh8000);
    queue_left(1, 0, pick_elem());
    repeat (33) queue_left(1, 1, 16'sh8000);
    wait_drained();

    // ---- sender idles 36 %, receiver 48 % ----
    apply_size(5'd3);
    hold_kicks++;                    // long receiver hold-off, input backs up
    run_segment(12);
    run_segment(6);
    run_phase(5'd1, 6);

    // ---- roles swapped ----
    send_idle_pct  = 48;
    recv_stall_pct = 36;
    run_phase(5'd0, 4);              // zero behaves as size 1
    run_phase(5'd5, 6);
    apply_size(5'd31);               // clamps to 16
    queue_left(3, 15, pick_elem());  // last column alone: full 16-wide row out
    wait_drained();

    // ---- no idling on either side ----
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(5'd4, 8);

    if (expected_products.size() != 0) begin
      $error("%0d results never arrived", expected_products.size());
      mismatch_count++;
    end
    $display("Sent %0d requests; checked %0d results over %0d completed rows.",
             accepted_count, results_checked, rows_completed);
    $display("Sizes 0,1,2,3,4,5,31 with idling, hold-off, broken rows, 36-bit wrap.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dmm_pkg.sv
hw/rtl/dmm_ram.sv
hw/rtl/dense_matrix_multiply.sv
hw/rtl/dmm_checker.sv
test/tb_top.sv
